### design/tcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, codes and helpers for the timecode counter with packed load.
// ----------------------------------------------------------------------------
package tcp_pkg;

    // Action codes carried by each input word.
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_OFFSET = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_MODE = 2'd1;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [5:0] RATE_RESET = 6'd30;
    localparam logic [5:0] RATE_DROP  = 6'd30;
    localparam logic [5:0] RATE_PAL   = 6'd25;

    localparam logic [6:0] SEC_PER_MIN  = 7'd60;
    localparam logic [6:0] MIN_PER_HOUR = 7'd60;
    localparam logic [6:0] HOUR_PER_DAY = 7'd24;
    localparam logic [6:0] LAST_SEC     = 7'd59;
    localparam logic [6:0] LAST_MIN     = 7'd59;
    localparam logic [5:0] LAST_HOUR    = 6'd23;
    localparam logic [5:0] DROP_SKIP    = 6'd2;

    localparam int unsigned DROP_BIT      = 10;
    localparam int unsigned FIELD_BIT     = 27;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_PACK
    } t_tcp_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic pack;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
    } t_dp_stat;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_bcd;

    // Splits a value below 128 into tens and units. 205/2048 is close enough
    // to 1/10 that the quotient is exact over this range.
    function automatic t_bcd tcp_split(input logic [6:0] value);
        logic [14:0] prod;
        logic [6:0]  tens_x10;
        t_bcd        res;
        prod      = 15'(value) * 15'd205;
        res.tens  = prod[14:11];
        tens_x10  = 7'(res.tens) * 7'd10;
        res.units = 4'(value - tens_x10);
        return res;
    endfunction

endpackage

### design/timecode_counter_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timecode_counter_pack
// Timecode counter with packed BCD load, signed offset stepping and repack.
// ----------------------------------------------------------------------------
// Usage: each input word carries an action (load, offset or read), the two
// packed load halves and a signed step count. A word is taken when
// i_in_valid is high and o_in_stall is low; one result word (the repacked
// timecode) follows for every input word on the o_out_valid / i_out_stall
// channel. Configuration (frame rate, field mode) is written through the
// i_cfg_* channel, which is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this. Timing: a
// load passes through S_LOAD and a read goes straight to S_PACK; an offset
// stays in S_STEP until its count is zero, since the stepping unit advances
// the timecode by one frame or field per cycle. S_PACK writes the result to
// the output register; the next word is accepted on the cycle after that.
// A stalled result stays in the output register; the block may accept and
// process one more word meanwhile and then waits with o_in_stall high until
// the held result is taken. Synchronous reset clears the timecode to zero,
// sets the frame rate to 30 and field mode off, and empties the output.
// ----------------------------------------------------------------------------
module timecode_counter_pack #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_action,
    input  logic [31:0]                          i_load_low,
    input  logic [31:0]                          i_load_high,
    input  logic signed [COUNT_WIDTH-1:0]        i_step_count,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [31:0]                          o_packed_low,
    output logic [31:0]                          o_packed_high,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tcp_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tcp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    tcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    tcp_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_load_low    (i_load_low),
        .i_load_high   (i_load_high),
        .i_step_count  (i_step_count),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_packed_low  (o_packed_low),
        .o_packed_high (o_packed_high)
    );

endmodule

### design/tcp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_ctrl
// Sequencer: accepts one word, runs load or stepping (a read needs neither),
// then fills the output register when it is free.
// ----------------------------------------------------------------------------
module tcp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output tcp_pkg::t_dp_cmd  o_cmd,
    input  tcp_pkg::t_dp_stat i_stat
);
    import tcp_pkg::*;

    t_tcp_state r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_accept;
    logic       out_free;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_action == ACT_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_action == ACT_OFFSET) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_PACK;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_PACK;
            end
            S_STEP: begin
                if (i_stat.count_zero) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.pack    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            S_STEP: begin
                o_cmd.step = !i_stat.count_zero;
            end
            S_PACK: begin
                o_cmd.pack = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.pack) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != S_IDLE)
        else $error("accepted word did not start processing");

    a_pack_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pack |=> o_out_valid)
        else $error("result not presented after pack");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !o_cmd.pack)
        else $error("held result overwritten");

endmodule

### design/tcp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_dp
// Timecode registers, configuration, load unpacker, one-step stepping unit
// and the repacking output register.
// ----------------------------------------------------------------------------
module tcp_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tcp_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [31:0]                           i_load_low,
    input  logic [31:0]                           i_load_high,
    input  logic signed [COUNT_WIDTH-1:0]         i_step_count,
    input  tcp_pkg::t_dp_cmd                      i_cmd,
    output tcp_pkg::t_dp_stat                     o_stat,
    output logic [31:0]                           o_packed_low,
    output logic [31:0]                           o_packed_high
);
    import tcp_pkg::*;

    // Configuration
    logic [5:0] r_frame_rate;
    logic       r_field_mode;

    // Timecode state
    logic [5:0]  r_hour, n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic [5:0]  r_frame, n_frame;
    logic        r_drop, n_drop;
    logic        r_field, n_field;
    logic [31:0] r_user, n_user;

    // Captured word and step counter
    logic [31:0]            r_load_low, r_load_high;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_down, n_down;
    logic [COUNT_WIDTH-1:0] count_raw;

    logic [31:0] r_out_low, r_out_high;
    logic [31:0] pack_low, pack_high;

    logic rate_drop, rate_pal, rate_zero;

    // Step up results
    logic [6:0] uf, us, um, uh;
    logic       up_field, up_adv;
    t_bcd       um_bcd;

    // Step down results
    logic [5:0] df, dh;
    logic [6:0] ds, dm;
    logic       dn_field, dn_adv;
    t_bcd       dm_bcd;

    t_bcd fr_bcd, se_bcd, mi_bcd, ho_bcd;

    assign rate_drop = (r_frame_rate == RATE_DROP);
    assign rate_pal  = (r_frame_rate == RATE_PAL);
    assign rate_zero = (r_frame_rate == 6'd0);

    assign o_stat.count_zero = (r_count == '0);

    always_comb begin
        up_field = r_field;
        up_adv   = 1'b1;
        if (r_field_mode) begin
            if (!r_field) begin
                up_field = 1'b1;
                up_adv   = 1'b0;
            end else begin
                up_field = 1'b0;
            end
        end
        uf = {1'b0, r_frame} + 7'd1;
        us = r_second;
        um = r_minute;
        uh = {1'b0, r_hour};
        if (uf >= {1'b0, r_frame_rate}) begin
            uf = 7'd0;
            us = us + 7'd1;
        end
        if (us >= SEC_PER_MIN) begin
            us = 7'd0;
            um = um + 7'd1;
        end
        if (um >= MIN_PER_HOUR) begin
            um = 7'd0;
            uh = uh + 7'd1;
        end
        um_bcd = tcp_split(um);
        // Drop frame: frames 0 and 1 are skipped at the top of each minute
        // except every tenth one.
        if (r_drop && rate_drop && um_bcd.units != 4'd0 && us == 7'd0 && uf == 7'd0) begin
            uf = {1'b0, DROP_SKIP};
        end
        if (uh >= HOUR_PER_DAY) begin
            uh = 7'd0;
        end
    end

    always_comb begin
        dn_field = r_field;
        dn_adv   = 1'b1;
        if (r_field_mode) begin
            if (r_field) begin
                dn_field = 1'b0;
                dn_adv   = 1'b0;
            end else begin
                dn_field = 1'b1;
            end
        end
        df     = r_frame;
        ds     = r_second;
        dm     = r_minute;
        dh     = r_hour;
        dm_bcd = tcp_split(r_minute);
        if (r_drop && rate_drop && dm_bcd.units != 4'd0 && ds == 7'd0 && df == DROP_SKIP) begin
            df = 6'd0;
        end
        if (df == 6'd0) begin
            df = r_frame_rate - 6'd1;
            if (ds == 7'd0) begin
                ds = LAST_SEC;
                if (dm == 7'd0) begin
                    dm = LAST_MIN;
                    dh = (dh == 6'd0) ? LAST_HOUR : dh - 6'd1;
                end else begin
                    dm = dm - 7'd1;
                end
            end else begin
                ds = ds - 7'd1;
            end
        end else begin
            df = df - 6'd1;
        end
    end

    assign count_raw = i_step_count;

    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_frame  = r_frame;
        n_drop   = r_drop;
        n_field  = r_field;
        n_user   = r_user;
        n_count  = r_count;
        n_down   = r_down;
        if (i_cmd.capture) begin
            n_down  = count_raw[COUNT_WIDTH-1];
            n_count = count_raw[COUNT_WIDTH-1] ? (~count_raw + COUNT_WIDTH'(1)) : count_raw;
        end
        if (i_cmd.load) begin
            n_frame  = 6'(r_load_low[3:0]) + 6'(r_load_low[9:8]) * 6'd10;
            n_second = 7'(r_load_low[19:16]) + 7'(r_load_low[26:24]) * 7'd10;
            n_minute = 7'(r_load_high[3:0]) + 7'(r_load_high[10:8]) * 7'd10;
            n_hour   = 6'(r_load_high[19:16]) + 6'(r_load_high[25:24]) * 6'd10;
            n_user   = {r_load_high[31:28], r_load_high[23:20], r_load_high[15:12],
                        r_load_high[7:4], r_load_low[31:28], r_load_low[23:20],
                        r_load_low[15:12], r_load_low[7:4]};
            n_drop   = rate_drop && r_load_low[DROP_BIT];
            n_field  = r_field_mode &&
                       (rate_pal ? r_load_high[FIELD_BIT] : r_load_low[FIELD_BIT]);
        end
        if (i_cmd.step) begin
            n_count = r_count - COUNT_WIDTH'(1);
            if (!rate_zero) begin
                if (r_down) begin
                    n_field = dn_field;
                    if (dn_adv) begin
                        n_frame  = df;
                        n_second = ds;
                        n_minute = dm;
                        n_hour   = dh;
                    end
                end else begin
                    n_field = up_field;
                    if (up_adv) begin
                        n_frame  = uf[5:0];
                        n_second = us;
                        n_minute = um;
                        n_hour   = uh[5:0];
                    end
                end
            end
        end
    end

    always_comb begin
        fr_bcd = tcp_split({1'b0, r_frame});
        se_bcd = tcp_split(r_second);
        mi_bcd = tcp_split(r_minute);
        ho_bcd = tcp_split({1'b0, r_hour});
        pack_low = {r_user[15:12],
                    r_field_mode && r_field && !rate_pal,
                    se_bcd.tens[2:0],
                    r_user[11:8],
                    se_bcd.units,
                    r_user[7:4],
                    1'b0,
                    rate_drop && r_drop,
                    fr_bcd.tens[1:0],
                    r_user[3:0],
                    fr_bcd.units};
        pack_high = {r_user[31:28],
                     r_field_mode && r_field && rate_pal,
                     1'b0,
                     ho_bcd.tens[1:0],
                     r_user[27:24],
                     ho_bcd.units,
                     r_user[23:20],
                     1'b0,
                     mi_bcd.tens[2:0],
                     r_user[19:16],
                     mi_bcd.units};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= RATE_RESET;
            r_field_mode <= 1'b0;
            r_hour       <= '0;
            r_minute     <= '0;
            r_second     <= '0;
            r_frame      <= '0;
            r_drop       <= 1'b0;
            r_field      <= 1'b0;
            r_user       <= '0;
            r_count      <= '0;
            r_down       <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_FRAME_RATE) begin
                r_frame_rate <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_FIELD_MODE) begin
                r_field_mode <= i_cfg_data[0];
            end
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_frame  <= n_frame;
            r_drop   <= n_drop;
            r_field  <= n_field;
            r_user   <= n_user;
            r_count  <= n_count;
            r_down   <= n_down;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_load_low  <= i_load_low;
            r_load_high <= i_load_high;
        end
        if (i_cmd.pack) begin
            r_out_low  <= pack_low;
            r_out_high <= pack_high;
        end
    end

    assign o_packed_low  = r_out_low;
    assign o_packed_high = r_out_high;

    a_step_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> r_count == $past(r_count) - COUNT_WIDTH'(1))
        else $error("step counter did not decrement");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_frame <= 6'd45 && r_hour <= 6'd45))
        else $error("loaded count outside its BCD range");

endmodule

### dv/timecode_counter_pack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timecode_counter_pack_tb
// Self-checking bench for the timecode counter with packed BCD load.
// A short table of directed words (reset state, extremes of the step count,
// drop-frame skips, the 24 hour wrap, field flags at 30 and 25 fps, frozen
// rate) is followed by random phases under several frame rates and field
// modes. Every accepted word is run through a local timecode predictor and
// each result word is compared against the oldest prediction. The sender
// works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module timecode_counter_pack_tb;
    import tcp_pkg::*;

    localparam int STEP_W = 16;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 53;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_action = ACT_READ;
    logic [31:0]                   i_load_low = '0;
    logic [31:0]                   i_load_high = '0;
    logic signed [STEP_W-1:0]      i_step_count = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [31:0]                   o_packed_low;
    logic [31:0]                   o_packed_high;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_W-1:0]        i_cfg_index = CFG_FRAME_RATE;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    timecode_counter_pack #(
        .COUNT_WIDTH(STEP_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_load_low    (i_load_low),
        .i_load_high   (i_load_high),
        .i_step_count  (i_step_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_packed_low  (o_packed_low),
        .o_packed_high (o_packed_high),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Timecode predictor
    // ------------------------------------------------------------------
    logic [5:0]  cfg_rate  = RATE_RESET;
    logic        cfg_field = 1'b0;

    logic [5:0]  tc_hours;
    logic [6:0]  tc_minutes;
    logic [6:0]  tc_seconds;
    logic [5:0]  tc_frames;
    logic        tc_drop;
    logic        tc_field;
    logic [31:0] tc_user;

    logic [63:0] packed_tc_q[$];
    int unsigned mismatch_count = 0;
    int          burst_left = 1;

    function automatic void tc_clear();
        cfg_rate   = RATE_RESET;
        cfg_field  = 1'b0;
        tc_hours   = '0;
        tc_minutes = '0;
        tc_seconds = '0;
        tc_frames  = '0;
        tc_drop    = 1'b0;
        tc_field   = 1'b0;
        tc_user    = '0;
    endfunction

    function automatic void tc_load(input logic [31:0] lo, input logic [31:0] hi);
        tc_frames  = 6'(lo[3:0] + lo[9:8] * 10);
        tc_seconds = 7'(lo[19:16] + lo[26:24] * 10);
        tc_minutes = 7'(hi[3:0] + hi[10:8] * 10);
        tc_hours   = 6'(hi[19:16] + hi[25:24] * 10);
        tc_user    = {hi[31:28], hi[23:20], hi[15:12], hi[7:4],
                      lo[31:28], lo[23:20], lo[15:12], lo[7:4]};
        tc_drop    = (cfg_rate == RATE_DROP) ? lo[DROP_BIT] : 1'b0;
        tc_field   = 1'b0;
        if (cfg_field) begin
            tc_field = (cfg_rate == RATE_PAL) ? hi[FIELD_BIT] : lo[FIELD_BIT];
        end
    endfunction

    function automatic logic [63:0] tc_pack();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = '0;
        hi = '0;
        lo[3:0]   = 4'(tc_frames % 10);
        lo[7:4]   = tc_user[3:0];
        lo[9:8]   = 2'(tc_frames / 10);
        lo[15:12] = tc_user[7:4];
        lo[19:16] = 4'(tc_seconds % 10);
        lo[23:20] = tc_user[11:8];
        lo[26:24] = 3'(tc_seconds / 10);
        lo[31:28] = tc_user[15:12];
        hi[3:0]   = 4'(tc_minutes % 10);
        hi[7:4]   = tc_user[19:16];
        hi[10:8]  = 3'(tc_minutes / 10);
        hi[15:12] = tc_user[23:20];
        hi[19:16] = 4'(tc_hours % 10);
        hi[23:20] = tc_user[27:24];
        hi[25:24] = 2'(tc_hours / 10);
        hi[31:28] = tc_user[31:28];
        if (cfg_rate == RATE_DROP && tc_drop) begin
            lo[DROP_BIT] = 1'b1;
        end
        if (cfg_field && tc_field) begin
            if (cfg_rate == RATE_PAL) begin
                hi[FIELD_BIT] = 1'b1;
            end else begin
                lo[FIELD_BIT] = 1'b1;
            end
        end
        return {hi, lo};
    endfunction

    // True at frame frame_at of the first second of a minute not divisible by
    // ten, where drop frame skips frame numbers zero and one.
    function automatic logic at_drop_point(input logic [5:0] frame_at);
        return tc_drop && cfg_rate == RATE_DROP && (tc_minutes % 10) != 0 &&
               tc_seconds == 0 && tc_frames == frame_at;
    endfunction

    function automatic void tc_step_up();
        if (cfg_rate == 0) begin
            return;
        end
        if (cfg_field) begin
            if (!tc_field) begin
                tc_field = 1'b1;
                return;
            end
            tc_field = 1'b0;
        end
        tc_frames = tc_frames + 6'd1;
        if (tc_frames >= cfg_rate) begin
            tc_frames  = '0;
            tc_seconds = tc_seconds + 7'd1;
        end
        if (tc_seconds >= SEC_PER_MIN) begin
            tc_seconds = '0;
            tc_minutes = tc_minutes + 7'd1;
        end
        if (tc_minutes >= MIN_PER_HOUR) begin
            tc_minutes = '0;
            tc_hours   = tc_hours + 6'd1;
        end
        if (at_drop_point(6'd0)) begin
            tc_frames = DROP_SKIP;
        end
        if (tc_hours >= 6'(HOUR_PER_DAY)) begin
            tc_hours = '0;
        end
    endfunction

    function automatic void tc_step_down();
        if (cfg_rate == 0) begin
            return;
        end
        if (cfg_field) begin
            if (tc_field) begin
                tc_field = 1'b0;
                return;
            end
            tc_field = 1'b1;
        end
        if (at_drop_point(DROP_SKIP)) begin
            tc_frames = '0;
        end
        if (tc_frames == 0) begin
            tc_frames = cfg_rate - 6'd1;
            if (tc_seconds == 0) begin
                tc_seconds = LAST_SEC;
                if (tc_minutes == 0) begin
                    tc_minutes = LAST_MIN;
                    tc_hours   = (tc_hours == 0) ? LAST_HOUR : tc_hours - 6'd1;
                end else begin
                    tc_minutes = tc_minutes - 7'd1;
                end
            end else begin
                tc_seconds = tc_seconds - 7'd1;
            end
        end else begin
            tc_frames = tc_frames - 6'd1;
        end
    endfunction

    function automatic void tc_offset(input logic [STEP_W-1:0] cnt);
        int n;
        n = cnt[STEP_W-1] ? ((1 << STEP_W) - int'(cnt)) : int'(cnt);
        for (int i = 0; i < n; i++) begin
            if (cnt[STEP_W-1]) begin
                tc_step_down();
            end else begin
                tc_step_up();
            end
        end
    endfunction

    // Advances the predictor by one accepted word and queues the repacked
    // timecode, or the typed-in value where the table gives one.
    function automatic void tc_take_word(input logic [1:0] act, input logic [31:0] lo,
                                         input logic [31:0] hi,
                                         input logic [STEP_W-1:0] cnt,
                                         input logic known, input logic [63:0] known_word);
        case (act)
            ACT_LOAD:   tc_load(lo, hi);
            ACT_OFFSET: tc_offset(cnt);
            default:    ;
        endcase
        packed_tc_q.push_back(known ? known_word : tc_pack());
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        logic [63:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (packed_tc_q.size() == 0) begin
                $error("unexpected result word: low %h, high %h", o_packed_low, o_packed_high);
                mismatch_count++;
            end else begin
                want = packed_tc_q.pop_front();
                if (o_packed_low !== want[31:0]) begin
                    $error("packed_low: expected %h, actual %h", want[31:0], o_packed_low);
                    mismatch_count++;
                end
                if (o_packed_high !== want[63:32]) begin
                    $error("packed_high: expected %h, actual %h", want[63:32], o_packed_high);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall pattern: stretches of no stall, light random stall and
    // heavy stall, each of random length.
    int stall_mode = 0;
    int stall_left = 30;

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 60);
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [5:0]        rate;
        logic              fmode;
        logic [1:0]        action;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [STEP_W-1:0] cnt;
        logic              known;
        logic [63:0]       known_word;
    } t_stim_row;

    t_stim_row stim_rows[$];

    function automatic void add_row(input logic [5:0] rate, input logic fmode,
                                    input logic [1:0] act, input logic [31:0] lo,
                                    input logic [31:0] hi, input logic [STEP_W-1:0] cnt,
                                    input logic known, input logic [63:0] known_word);
        t_stim_row r;
        r.rate       = rate;
        r.fmode      = fmode;
        r.action     = act;
        r.lo         = lo;
        r.hi         = hi;
        r.cnt        = cnt;
        r.known      = known;
        r.known_word = known_word;
        stim_rows.push_back(r);
    endfunction

    // Sends one word and waits for it to be taken. Valid stays high into the
    // next word only when more follows within the current burst.
    task automatic send_word(input logic [1:0] act, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [STEP_W-1:0] cnt,
                             input logic known, input logic [63:0] known_word,
                             input logic more);
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_load_low   <= lo;
        i_load_high  <= hi;
        i_step_count <= cnt;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        tc_take_word(act, lo, hi, cnt, known, known_word);
        burst_left--;
        if (!more) begin
            i_in_valid <= 1'b0;
        end else if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic wait_idle();
        while (packed_tc_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [5:0] rate, input logic fmode);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FRAME_RATE;
        i_cfg_data  <= CFG_DATA_W'(rate);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        cfg_rate = rate;
        i_cfg_index <= CFG_FIELD_MODE;
        i_cfg_data  <= CFG_DATA_W'(fmode);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        cfg_field = fmode;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] pick_action();
        int p;
        p = $urandom_range(0, 99);
        if (p < 28) begin
            return ACT_LOAD;
        end else if (p < 83) begin
            return ACT_OFFSET;
        end else if (p < 95) begin
            return ACT_READ;
        end
        return ACT_SPARE;
    endfunction

    // Mostly small counts around a boundary, a few long runs.
    function automatic logic [STEP_W-1:0] pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) begin
            return STEP_W'(int'($urandom_range(0, 80)) - 40);
        end else if (p < 90) begin
            return STEP_W'(int'($urandom_range(0, 3000)) - 1500);
        end else if (p < 99) begin
            return STEP_W'(int'($urandom_range(0, 8000)) - 4000);
        end
        return STEP_W'($urandom);
    endfunction

    // Well-formed timecodes near minute, hour and day boundaries with random
    // user bits and flags; the rest are raw random words.
    function automatic logic [63:0] pick_load();
        logic [31:0] lo;
        logic [31:0] hi;
        int h;
        int m;
        int s;
        int f;
        int top;
        if ($urandom_range(0, 9) < 3) begin
            return {$urandom, $urandom};
        end
        case ($urandom_range(0, 3))
            0:       h = 23;
            1:       h = 0;
            2:       h = 9 + 10 * int'($urandom_range(0, 1));
            default: h = $urandom_range(0, 23);
        endcase
        case ($urandom_range(0, 3))
            0:       m = 59;
            1:       m = 9;
            2:       m = 0;
            default: m = $urandom_range(0, 59);
        endcase
        if ($urandom_range(0, 9) < 6) begin
            s = 59;
        end else if ($urandom_range(0, 1) == 0) begin
            s = 0;
        end else begin
            s = $urandom_range(0, 59);
        end
        top = (cfg_rate == 0) ? 0 : int'(cfg_rate) - 1;
        if (top > 39) begin
            top = 39;
        end
        if ($urandom_range(0, 9) < 6) begin
            f = top - int'($urandom_range(0, 2));
        end else begin
            f = $urandom_range(0, 39);
        end
        if (f < 0) begin
            f = 0;
        end
        lo = $urandom;
        hi = $urandom;
        lo[3:0]   = 4'(f % 10);
        lo[9:8]   = 2'(f / 10);
        lo[19:16] = 4'(s % 10);
        lo[26:24] = 3'(s / 10);
        hi[3:0]   = 4'(m % 10);
        hi[10:8]  = 3'(m / 10);
        hi[19:16] = 4'(h % 10);
        hi[25:24] = 2'(h / 10);
        return {hi, lo};
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_stim_row   r;
        logic        more;
        logic [5:0]  phase_rate[PHASES];
        logic        phase_field[PHASES];
        logic [1:0]  act;
        logic [63:0] ld;
        logic [31:0] lo;
        logic [31:0] hi;

        tc_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state, then 23:59:59:29 loaded and stepped across midnight.
        add_row(6'd30, 1'b0, ACT_READ,   32'h0, 32'h0, 16'h0000, 1'b1, 64'h0);
        add_row(6'd30, 1'b0, ACT_LOAD,   32'h05090209, 32'h02030509, 16'h0000,
                1'b1, {32'h02030509, 32'h05090209});
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h0001, 1'b1, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'hFFFF,
                1'b1, {32'h02030509, 32'h05090209});
        // Out of range digits everywhere, then the extreme counts.
        add_row(6'd30, 1'b0, ACT_LOAD,   32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h0001, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h7FFF, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h8000, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_SPARE,  32'hFFFFFFFF, 32'h0, 16'h1234, 1'b0, 64'h0);
        // Drop frame: skip at minute one, none at minute ten, zero count.
        add_row(6'd30, 1'b0, ACT_LOAD,   32'h05090609, 32'h0, 16'h0000, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h0001, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'hFFFF, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_LOAD,   32'h05090609, 32'h00000009, 16'h0000, 1'b0, 64'h0);
        add_row(6'd30, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'h0001, 1'b0, 64'h0);
        // Field flag in the low word at 30 fps and in the high word at 25.
        add_row(6'd30, 1'b1, ACT_LOAD,   32'h08000400, 32'h0, 16'h0000, 1'b0, 64'h0);
        add_row(6'd30, 1'b1, ACT_OFFSET, 32'h0, 32'h0, 16'h0003, 1'b0, 64'h0);
        add_row(6'd30, 1'b1, ACT_OFFSET, 32'h0, 32'h0, 16'hFFFB, 1'b0, 64'h0);
        add_row(6'd25, 1'b1, ACT_LOAD,   32'h08000400, 32'h08000000, 16'h0000, 1'b0, 64'h0);
        add_row(6'd25, 1'b1, ACT_OFFSET, 32'h0, 32'h0, 16'd51, 1'b0, 64'h0);
        // A zero rate freezes the timecode, field flag included.
        add_row(6'd0,  1'b1, ACT_OFFSET, 32'h0, 32'h0, 16'd100, 1'b0, 64'h0);
        add_row(6'd0,  1'b1, ACT_OFFSET, 32'h0, 32'h0, 16'hFFF9, 1'b0, 64'h0);
        add_row(6'd60, 1'b0, ACT_LOAD,   32'h0, 32'h0, 16'h0000, 1'b0, 64'h0);
        add_row(6'd60, 1'b0, ACT_OFFSET, 32'h0, 32'h0, 16'hFFFF, 1'b0, 64'h0);
        add_row(6'd60, 1'b0, ACT_READ,   32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 64'h0);

        for (int k = 0; k < stim_rows.size(); k++) begin
            r = stim_rows[k];
            if (r.rate != cfg_rate || r.fmode != cfg_field) begin
                wait_idle();
                set_config(r.rate, r.fmode);
            end
            more = (k + 1 < stim_rows.size()) && stim_rows[k + 1].rate == r.rate &&
                   stim_rows[k + 1].fmode == r.fmode;
            send_word(r.action, r.lo, r.hi, r.cnt, r.known, r.known_word, more);
        end

        phase_rate  = '{6'd30, 6'd30, 6'd25, 6'd25, 6'd0, 6'd60, 6'd1, 6'd24, 6'd0, 6'd30};
        phase_field = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
        phase_rate[8]  = 6'($urandom_range(0, 60));
        phase_field[8] = 1'($urandom_range(0, 1));

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            set_config(phase_rate[p], phase_field[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                act = pick_action();
                if (act == ACT_LOAD) begin
                    ld = pick_load();
                end else begin
                    ld = {$urandom, $urandom};
                end
                lo = ld[31:0];
                hi = ld[63:32];
                send_word(act, lo, hi, pick_count(), 1'b0, 64'h0, i + 1 < PHASE_ITEMS);
            end
        end

        wait_idle();
        if (mismatch_count == 0 && packed_tc_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // The slowest run stays well under 10 ms of simulated time; this allows
    // 50 ms, five times that.
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
design/tcp_pkg.sv
design/tcp_ctrl.sv
design/tcp_dp.sv
design/timecode_counter_pack.sv
dv/timecode_counter_pack_tb.sv
